>>> design/sdbc_pkg.sv
// Shared types and constants for the sliding day bucket counters.
// No dependencies.
package sdbc_pkg;

   localparam int DAY_W = 32;
   localparam int AMT_W = 12;
   localparam int BKT_W = 8;

   typedef logic [DAY_W-1:0] day_type;
   typedef logic [AMT_W-1:0] amount_type;
   typedef logic [BKT_W-1:0] bucket_type;

   typedef enum logic {
      MODE_ADD   = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   localparam bucket_type BUCKET_MAX = {BKT_W{1'b1}};

endpackage

>>> design/sliding_day_bucket_counters.sv
// Sliding window of per-day saturating counters kept in a circular RAM.
// Depends on sdbc_pkg and sdbc_ram.
// Query: passes S_EVAL, plus S_QWAIT when the bucket is read from RAM; the result strobe is registered.
// Add: ends after S_EVAL if zero or dropped, else S_CLEAR for n buckets (0 .. WINDOW_DAYS), S_RD, S_WR.
// Reset clears anchor, pointer and data flag; the RAM is cleared on the first counted add.
// The result strobe lasts one cycle; the receiver cannot stall.
module sliding_day_bucket_counters #(
   parameter int WINDOW_DAYS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  sdbc_pkg::day_type    req_day_index,
   input  sdbc_pkg::amount_type req_amount,
   output logic                 rsp_valid,
   output sdbc_pkg::bucket_type rsp_day_total
);
   import sdbc_pkg::*;

   localparam int AW = $clog2(WINDOW_DAYS);
   localparam int CW = $clog2(WINDOW_DAYS + 1);
   localparam logic [AW-1:0]  LAST_SLOT = AW'(WINDOW_DAYS - 1);
   localparam logic [AW:0]    WIN_A = (AW+1)'(WINDOW_DAYS);
   localparam logic [CW-1:0]  WIN_C = CW'(WINDOW_DAYS);
   localparam day_type        WIN_D = DAY_W'(WINDOW_DAYS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_QWAIT,
      S_CLEAR,
      S_RD,
      S_WR
   } state_type;

   state_type     state_ff, state_in;
   logic          mode_ff, mode_in;
   day_type       day_ff, day_in;
   amount_type    amt_ff, amt_in;
   day_type       newest_ff, newest_in;
   logic          holds_ff, holds_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [CW-1:0] clr_cnt_ff, clr_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   bucket_type    rsp_total_ff, rsp_total_in;

   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   bucket_type    ram_wdata, ram_rdata;

   day_type       age, gap;
   logic          day_newer;
   logic [AW:0]   slot_sum, ptr_diff;
   logic [AW-1:0] age_slot, ptr_new;

   sdbc_ram #(
      .WIDTH(BKT_W),
      .DEPTH(WINDOW_DAYS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   logic [AMT_W:0] bucket_sum;

   always_comb begin
      day_newer = day_ff > newest_ff;
      age       = newest_ff - day_ff;
      gap       = day_ff - newest_ff;
      slot_sum  = {1'b0, ptr_ff} + {1'b0, age[AW-1:0]};
      age_slot  = (slot_sum >= WIN_A) ? AW'(slot_sum - WIN_A) : slot_sum[AW-1:0];
      ptr_diff  = (ptr_ff >= gap[AW-1:0]) ? {1'b0, ptr_ff} - {1'b0, gap[AW-1:0]}
                                           : {1'b0, ptr_ff} + WIN_A - {1'b0, gap[AW-1:0]};
      ptr_new   = ptr_diff[AW-1:0];
      bucket_sum = {{(AMT_W+1-BKT_W){1'b0}}, ram_rdata} + {1'b0, amt_ff};
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      day_in       = day_ff;
      amt_in       = amt_ff;
      newest_in    = newest_ff;
      holds_in     = holds_ff;
      ptr_in       = ptr_ff;
      slot_in      = slot_ff;
      clr_addr_in  = clr_addr_ff;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_total_in = rsp_total_ff;
      ram_we       = 1'b0;
      ram_waddr    = clr_addr_ff;
      ram_wdata    = '0;
      ram_raddr    = slot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               day_in   = req_day_index;
               amt_in   = req_amount;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            ram_raddr = age_slot;
            if (mode_ff == MODE_QUERY) begin
               if (!holds_ff || day_newer || age >= WIN_D) begin
                  rsp_valid_in = 1'b1;
                  rsp_total_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_QWAIT;
               end
            end else if (amt_ff == '0) begin
               state_in = S_IDLE;
            end else if (!holds_ff) begin
               newest_in   = day_ff;
               slot_in     = ptr_ff;
               clr_addr_in = '0;
               clr_cnt_in  = WIN_C;
               state_in    = S_CLEAR;
            end else if (day_newer) begin
               newest_in = day_ff;
               if (gap >= WIN_D) begin
                  slot_in     = ptr_ff;
                  clr_addr_in = '0;
                  clr_cnt_in  = WIN_C;
               end else begin
                  ptr_in      = ptr_new;
                  slot_in     = ptr_new;
                  clr_addr_in = ptr_new;
                  clr_cnt_in  = CW'(gap[AW-1:0]);
               end
               state_in = S_CLEAR;
            end else if (age >= WIN_D) begin
               state_in = S_IDLE;
            end else begin
               slot_in  = age_slot;
               state_in = S_RD;
            end
         end
         S_QWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_total_in = ram_rdata;
            state_in     = S_IDLE;
         end
         S_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = (clr_addr_ff == LAST_SLOT) ? '0 : clr_addr_ff + 1'b1;
            clr_cnt_in  = clr_cnt_ff - 1'b1;
            if (clr_cnt_ff == CW'(1)) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            ram_we    = 1'b1;
            ram_waddr = slot_ff;
            ram_wdata = (bucket_sum > {{(AMT_W+1-BKT_W){1'b0}}, BUCKET_MAX})
                        ? BUCKET_MAX : bucket_sum[BKT_W-1:0];
            holds_in  = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         newest_ff    <= '0;
         holds_ff     <= 1'b0;
         ptr_ff       <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         holds_ff     <= holds_in;
         ptr_ff       <= ptr_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      day_ff       <= day_in;
      amt_ff       <= amt_in;
      slot_ff      <= slot_in;
      clr_addr_ff  <= clr_addr_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_rsp_after_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(mode_ff == MODE_QUERY
                             && (state_ff == S_EVAL || state_ff == S_QWAIT)))
      else $error("result strobe without a query");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_WR))
      else $error("RAM write outside clear or update");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> (clr_cnt_ff != '0 && clr_cnt_ff <= WIN_C))
      else $error("clear count out of range");

   a_update_sets_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WR |=> holds_ff)
      else $error("data flag not set after update");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      holds_ff |=> holds_ff)
      else $error("data flag cleared");
`endif

endmodule

>>> design/sdbc_ram.sv
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module sdbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
